/* rtl/assert_macros.svh */
// Assertion macros used by the port-level checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define ASSERT_CLK(lbl, clk, rstn, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// Check that a condition never holds on a rising clock edge outside reset.
`define ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(cond)) else $error(msg);

`endif

/* rtl/ryuv_pkg.sv */
// Types and constants of the RGB to YCbCr 4:2:0 converter.
`default_nettype none
package ryuv_pkg;

	localparam int MAX_DIMENSION = 4096;
	localparam int CNT_W = $clog2(MAX_DIMENSION);
	localparam int SIZE_W = 13;
	localparam int COMP_W = 8;
	localparam int APB_AW = 3;
	localparam int APB_DW = 32;

	localparam logic [SIZE_W-1:0] WIDTH_RESET = SIZE_W'(640);
	localparam logic [SIZE_W-1:0] HEIGHT_RESET = SIZE_W'(480);

	typedef enum logic {
		REG_FRAME_WIDTH = 1'b0,
		REG_FRAME_HEIGHT = 1'b1
	} reg_index_t;

	typedef enum logic [1:0] {
		KIND_NONE = 2'd0,
		KIND_CB = 2'd1,
		KIND_CR = 2'd2
	} chroma_kind_t;

	// Last column and last row index of the frame, from the size registers.
	typedef struct packed {
		logic [CNT_W-1:0] col_last;
		logic [CNT_W-1:0] row_last;
	} frame_limits_t;

	// What the frame position says about the pixel being accepted.
	typedef struct packed {
		chroma_kind_t kind;
		logic frame_end;
	} pixel_pos_t;

	// Clamp a size register to 1..MAX_DIMENSION and return its last index.
	function automatic logic [CNT_W-1:0] last_index(input logic [SIZE_W-1:0] size);
		logic [CNT_W-1:0] idx;
		if (size == '0) begin
			idx = '0;
		end else if (32'(size) > MAX_DIMENSION) begin
			idx = CNT_W'(MAX_DIMENSION - 1);
		end else begin
			idx = CNT_W'(size - SIZE_W'(1));
		end
		return idx;
	endfunction

endpackage
`default_nettype wire

/* rtl/ryuv_pixel_if.sv */
// Input channel: one RGB888 pixel per item.
`default_nettype none
interface ryuv_pixel_if;
	logic valid;
	logic ready;
	logic [ryuv_pkg::COMP_W-1:0] red;
	logic [ryuv_pkg::COMP_W-1:0] green;
	logic [ryuv_pkg::COMP_W-1:0] blue;

	modport source (output valid, output red, output green, output blue, input ready);
	modport sink (input valid, input red, input green, input blue, output ready);
endinterface
`default_nettype wire

/* rtl/ryuv_result_if.sv */
// Output channel: luma, decimated chroma and frame end per item.
`default_nettype none
interface ryuv_result_if;
	logic valid;
	logic ready;
	logic [7:0] luma;
	logic [7:0] chroma;
	ryuv_pkg::chroma_kind_t chroma_kind;
	logic frame_end;

	modport source (output valid, output luma, output chroma, output chroma_kind,
		output frame_end, input ready);
	modport sink (input valid, input luma, input chroma, input chroma_kind,
		input frame_end, output ready);
endinterface
`default_nettype wire

/* rtl/rgb_to_yuv420_converter_unit.sv */
// Top level of the RGB888 to BT.601 YCbCr 4:2:0 pixel-stream converter.
//
//   channel  dir  handshake        payload
//   pixel    in   valid / ready    red, green, blue (8 bits each)
//   result   out  valid / ready    luma, chroma, chroma_kind, frame_end
//   apb      in   psel / penable   frame_width (addr 0), frame_height (addr 4)
//
// One item per cycle sustained while the result is taken; each item passes the input and result registers.
// The input register feeds the color math, whose output is held in the result register.
// Reset clears the frame counters and both stage valid bits, and loads 640 x 480.
// A stalled result holds in place; the input stage still takes one item if it is empty.
`default_nettype none
module rgb_to_yuv420_converter_unit (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        psel,
	input  wire logic                        penable,
	input  wire logic                        pwrite,
	input  wire logic [ryuv_pkg::APB_AW-1:0] paddr,
	input  wire logic [ryuv_pkg::APB_DW-1:0] pwdata,
	output logic      [ryuv_pkg::APB_DW-1:0] prdata,
	output logic                             pready,
	ryuv_pixel_if.sink                       pixel,
	ryuv_result_if.source                    result
);
	import ryuv_pkg::*;

	frame_limits_t     limits;
	pixel_pos_t        pos;
	logic              take_in;
	logic              adv_s1;
	logic              valid_s1;
	logic [COMP_W-1:0] red_s1;
	logic [COMP_W-1:0] green_s1;
	logic [COMP_W-1:0] blue_s1;
	chroma_kind_t      kind_s1;
	logic              end_s1;
	logic [7:0]        luma_c;
	logic [7:0]        chroma_c;
	logic              valid_s2;
	logic [7:0]        luma_s2;
	logic [7:0]        chroma_s2;
	chroma_kind_t      kind_s2;
	logic              end_s2;

	ryuv_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.limits  (limits)
	);

	ryuv_frame_pos u_pos (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (take_in),
		.limits  (limits),
		.pos     (pos)
	);

	ryuv_color_math u_math (
		.red    (red_s1),
		.green  (green_s1),
		.blue   (blue_s1),
		.kind   (kind_s1),
		.luma   (luma_c),
		.chroma (chroma_c)
	);

	assign adv_s1 = valid_s1 && (!valid_s2 || result.ready);
	assign pixel.ready = !valid_s1 || adv_s1;
	assign take_in = pixel.valid && pixel.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (take_in) begin
				valid_s1 <= 1'b1;
			end else if (adv_s1) begin
				valid_s1 <= 1'b0;
			end
			if (adv_s1) begin
				valid_s2 <= 1'b1;
			end else if (result.ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take_in) begin
			red_s1 <= pixel.red;
			green_s1 <= pixel.green;
			blue_s1 <= pixel.blue;
			kind_s1 <= pos.kind;
			end_s1 <= pos.frame_end;
		end
		if (adv_s1) begin
			luma_s2 <= luma_c;
			chroma_s2 <= chroma_c;
			kind_s2 <= kind_s1;
			end_s2 <= end_s1;
		end
	end

	assign result.valid = valid_s2;
	assign result.luma = luma_s2;
	assign result.chroma = chroma_s2;
	assign result.chroma_kind = kind_s2;
	assign result.frame_end = end_s2;
endmodule
`default_nettype wire

/* rtl/ryuv_cfg_regs.sv */
// APB register file holding the frame width and height.
`default_nettype none
module ryuv_cfg_regs (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         psel,
	input  wire logic                         penable,
	input  wire logic                         pwrite,
	input  wire logic [ryuv_pkg::APB_AW-1:0]  paddr,
	input  wire logic [ryuv_pkg::APB_DW-1:0]  pwdata,
	output logic      [ryuv_pkg::APB_DW-1:0]  prdata,
	output logic                              pready,
	output ryuv_pkg::frame_limits_t           limits
);
	import ryuv_pkg::*;

	logic [SIZE_W-1:0] width_q;
	logic [SIZE_W-1:0] height_q;
	reg_index_t        index;
	logic              wr_en;

	assign pready = 1'b1;
	assign index = reg_index_t'(paddr[2]);
	assign wr_en = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= WIDTH_RESET;
			height_q <= HEIGHT_RESET;
		end else if (wr_en) begin
			case (index)
				REG_FRAME_WIDTH: width_q <= pwdata[SIZE_W-1:0];
				REG_FRAME_HEIGHT: height_q <= pwdata[SIZE_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (index)
			REG_FRAME_WIDTH: prdata = APB_DW'(width_q);
			REG_FRAME_HEIGHT: prdata = APB_DW'(height_q);
			default: prdata = '0;
		endcase
	end

	assign limits.col_last = last_index(width_q);
	assign limits.row_last = last_index(height_q);
endmodule
`default_nettype wire

/* rtl/ryuv_frame_pos.sv */
// Column and row counters that place each accepted pixel in the frame.
`default_nettype none
module ryuv_frame_pos (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    advance,
	input  wire ryuv_pkg::frame_limits_t limits,
	output ryuv_pkg::pixel_pos_t         pos
);
	import ryuv_pkg::*;

	logic [CNT_W-1:0] col_q;
	logic [CNT_W-1:0] row_q;
	logic             last_col;
	logic             last_row;

	// At or past the last index counts as last, so a shrunk frame wraps at once.
	assign last_col = col_q >= limits.col_last;
	assign last_row = row_q >= limits.row_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (advance) begin
			if (last_col) begin
				col_q <= '0;
				row_q <= last_row ? '0 : row_q + CNT_W'(1);
			end else begin
				col_q <= col_q + CNT_W'(1);
			end
		end
	end

	always_comb begin
		if (col_q[0]) begin
			pos.kind = KIND_NONE;
		end else if (row_q[0]) begin
			pos.kind = KIND_CR;
		end else begin
			pos.kind = KIND_CB;
		end
		pos.frame_end = last_col && last_row;
	end
endmodule
`default_nettype wire

/* rtl/ryuv_color_math.sv */
// BT.601 studio-range luma and chroma from one registered RGB pixel.
`default_nettype none
module ryuv_color_math (
	input  wire logic [ryuv_pkg::COMP_W-1:0] red,
	input  wire logic [ryuv_pkg::COMP_W-1:0] green,
	input  wire logic [ryuv_pkg::COMP_W-1:0] blue,
	input  wire ryuv_pkg::chroma_kind_t      kind,
	output logic      [7:0]                  luma,
	output logic      [7:0]                  chroma
);
	import ryuv_pkg::*;

	logic        [16:0] y_sum;
	logic signed [17:0] sr;
	logic signed [17:0] sg;
	logic signed [17:0] sb;
	logic signed [17:0] cb_sum;
	logic signed [17:0] cr_sum;

	assign sr = $signed({10'b0, red});
	assign sg = $signed({10'b0, green});
	assign sb = $signed({10'b0, blue});

	assign y_sum = 17'd66 * {9'b0, red} + 17'd129 * {9'b0, green}
		+ 17'd25 * {9'b0, blue} + 17'd128;
	assign cb_sum = 18'sd112 * sb - 18'sd38 * sr - 18'sd74 * sg + 18'sd128;
	assign cr_sum = 18'sd112 * sr - 18'sd94 * sg - 18'sd18 * sb + 18'sd128;

	// Bits 15:8 give the floor shift modulo 256; the offsets land in range.
	assign luma = y_sum[15:8] + 8'd16;

	always_comb begin
		case (kind)
			KIND_CB: chroma = cb_sum[15:8] + 8'd128;
			KIND_CR: chroma = cr_sum[15:8] + 8'd128;
			default: chroma = 8'd0;
		endcase
	end
endmodule
`default_nettype wire

/* rtl/ryuv_checker.sv */
// Port-level checker for the converter and its bind to the top level.
`default_nettype none
`include "assert_macros.svh"
module ryuv_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       res_valid,
	input wire logic       res_ready,
	input wire logic [7:0] luma,
	input wire logic [7:0] chroma,
	input wire logic [1:0] kind
);
	import ryuv_pkg::*;

	`ASSERT_CLK(a_hold_stalled, clk, arst_n,
		res_valid && !res_ready |=> res_valid && $stable(luma) && $stable(chroma)
		&& $stable(kind), "stalled result changed")
	`ASSERT_CLK(a_luma_range, clk, arst_n,
		res_valid |-> luma >= 8'd16 && luma <= 8'd235, "luma out of range")
	`ASSERT_CLK(a_no_chroma_zero, clk, arst_n,
		res_valid && kind == KIND_NONE |-> chroma == 8'd0, "chroma set without kind")
	`ASSERT_CLK(a_chroma_range, clk, arst_n,
		res_valid && (kind == KIND_CB || kind == KIND_CR) |-> chroma >= 8'd16
		&& chroma <= 8'd240, "chroma out of range")
	`ASSERT_NEVER(a_bad_kind, clk, arst_n,
		res_valid && kind != KIND_NONE && kind != KIND_CB && kind != KIND_CR,
		"unknown chroma kind")
endmodule

bind rgb_to_yuv420_converter_unit ryuv_checker u_ryuv_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.res_valid (result.valid),
	.res_ready (result.ready),
	.luma      (result.luma),
	.chroma    (result.chroma),
	.kind      (result.chroma_kind)
);
`default_nettype wire
